/* sv/bchd_pkg.sv */
package bchd_pkg;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE_TIME  = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FINISH_TIMEOUT = 8'd1;

    localparam logic [CFG_DATA_WIDTH-1:0] DEBOUNCE_TIME_RESET  = 16'd50;
    localparam logic [CFG_DATA_WIDTH-1:0] FINISH_TIMEOUT_RESET = 16'd300;

    // stream field widths
    localparam int NOW_MS_WIDTH      = 32;
    localparam int EVENT_COUNT_WIDTH = 5;

    localparam logic EVT_CLICK = 1'b0;
    localparam logic EVT_HOLD  = 1'b1;

    typedef struct packed {
        logic                         valid;
        logic                         kind;
        logic [EVENT_COUNT_WIDTH-1:0] count;
    } t_event;

endpackage

/* sv/bchd_core.sv */
module bchd_core #(
    parameter int COUNT_WIDTH = 5,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_raw_pressed,
    input  logic [TIME_WIDTH-1:0]               i_now,
    input  logic [bchd_pkg::CFG_DATA_WIDTH-1:0] i_debounce_time,
    input  logic [bchd_pkg::CFG_DATA_WIDTH-1:0] i_finish_timeout,
    output bchd_pkg::t_event                    o_event
);
    import bchd_pkg::*;

    // now > base + delay, exact
    function automatic logic past(input logic [TIME_WIDTH-1:0] now,
                                  input logic [TIME_WIDTH-1:0] base,
                                  input logic [TIME_WIDTH-1:0] delay);
        logic [TIME_WIDTH-1:0] diff;
        diff = now - base;
        return (now > base) && (diff > delay);
    endfunction

    logic                   r_raw_last,  n_raw_last;
    logic [TIME_WIDTH-1:0]  r_raw_ct,    n_raw_ct;
    logic                   r_stable,    n_stable;
    logic [TIME_WIDTH-1:0]  r_stable_ct, n_stable_ct;
    logic                   r_prev,      n_prev;
    logic [COUNT_WIDTH-1:0] r_press,     n_press;
    logic [COUNT_WIDTH-1:0] r_release,   n_release;
    logic [COUNT_WIDTH-1:0] r_hold,      n_hold;
    logic                   r_finished,  n_finished;

    logic [TIME_WIDTH-1:0] deb_delay, fin_delay;
    logic past_deb, past_fin_raw, past_fin_stable, deb_take, past_fin;
    t_event ev;

    assign deb_delay = TIME_WIDTH'(i_debounce_time);
    assign fin_delay = TIME_WIDTH'(i_finish_timeout);

    // all three compares run in parallel off the registered state
    assign past_deb        = past(i_now, r_raw_ct, deb_delay);
    assign past_fin_raw    = past(i_now, r_raw_ct, fin_delay);
    assign past_fin_stable = past(i_now, r_stable_ct, fin_delay);

    always_comb begin
        n_raw_last  = r_raw_last;
        n_raw_ct    = r_raw_ct;
        n_stable    = r_stable;
        n_stable_ct = r_stable_ct;
        n_prev      = r_prev;
        n_press     = r_press;
        n_release   = r_release;
        n_hold      = r_hold;
        n_finished  = r_finished;
        deb_take    = 1'b0;
        ev          = '0;

        // debounce
        if (i_raw_pressed != r_raw_last) begin
            n_raw_last = i_raw_pressed;
            n_raw_ct   = i_now;
        end else if (r_stable_ct != r_raw_ct && past_deb) begin
            n_stable    = i_raw_pressed;
            n_stable_ct = r_raw_ct;
            deb_take    = 1'b1;
        end

        // stable edges
        if (r_prev != n_stable) begin
            if (!r_finished) begin
                if (n_stable) begin
                    n_press = n_press + COUNT_WIDTH'(1);
                end else begin
                    n_release = n_release + COUNT_WIDTH'(1);
                end
            end else if (!n_stable) begin
                n_press    = '0;
                n_release  = '0;
                n_hold     = '0;
                n_finished = 1'b0;
            end
            n_prev = n_stable;
        end

        past_fin = deb_take ? past_fin_raw : past_fin_stable;
        if (past_fin && (|{n_press, n_release, n_hold, n_finished})) begin
            n_finished = 1'b1;
        end

        // report
        if (n_finished) begin
            if (n_press == n_release) begin
                ev.valid   = 1'b1;
                ev.kind    = EVT_CLICK;
                ev.count   = EVENT_COUNT_WIDTH'(n_press);
                n_press    = '0;
                n_release  = '0;
                n_hold     = '0;
                n_finished = 1'b0;
            end else if (n_press > n_release) begin
                n_hold      = n_hold + COUNT_WIDTH'(1);
                ev.valid    = 1'b1;
                ev.kind     = EVT_HOLD;
                ev.count    = EVENT_COUNT_WIDTH'(n_hold);
                n_stable_ct = i_now;
                n_finished  = 1'b0;
            end else begin
                n_press    = '0;
                n_release  = '0;
                n_hold     = '0;
                n_finished = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_last  <= 1'b0;
            r_raw_ct    <= '0;
            r_stable    <= 1'b0;
            r_stable_ct <= '0;
            r_prev      <= 1'b0;
            r_press     <= '0;
            r_release   <= '0;
            r_hold      <= '0;
            r_finished  <= 1'b0;
        end else if (i_step) begin
            r_raw_last  <= n_raw_last;
            r_raw_ct    <= n_raw_ct;
            r_stable    <= n_stable;
            r_stable_ct <= n_stable_ct;
            r_prev      <= n_prev;
            r_press     <= n_press;
            r_release   <= n_release;
            r_hold      <= n_hold;
            r_finished  <= n_finished;
        end
    end

    always_comb begin
        o_event       = ev;
        o_event.valid = ev.valid & i_step;
    end

    // any reported event leaves no pending finish behind
    a_event_clears_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid |=> !r_finished)
        else $error("finished still set after an event");

    // a click empties the press and release record
    a_click_clears_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.kind == EVT_CLICK) |=> (r_press == '0 && r_release == '0))
        else $error("record not cleared after click");

    // the record only moves on an evaluated poll
    a_idle_holds_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_press) && $stable(r_release) && $stable(r_hold)))
        else $error("record changed without a poll");

endmodule

/* sv/button_click_hold_detector.sv */
// Button click and hold detector. Each input transfer is one poll of a push
// button: the raw level and the current millisecond timestamp. The level is
// debounced (it must hold for longer than debounce_time ms), stable presses
// and releases are counted, and once finish_timeout ms pass after the last
// stable change one event goes out: a click with the press count when the
// button is up, or a hold with a rising repeat count while it is still down,
// repeating after every further finish_timeout. Timestamps are compared
// unsigned without wrap handling; counters wrap at COUNT_WIDTH bits.
// Rate: one poll per clock, sustained. A poll goes into an input register,
// is evaluated combinationally against the state registers, and its event
// (if any) lands in a one-entry output register that drives o_m_axis_tvalid.
// The state update is done in the same cycle as that evaluation, which is
// what allows back-to-back polls; the input side stalls only while the
// output register is full and not taken.
// Configuration writes are taken in any cycle (o_cfg_ready is always high)
// but should only be issued while the block is idle.
module button_click_hold_detector #(
    parameter int COUNT_WIDTH = 5,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // poll stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [39:0]                          i_s_axis_tdata,  // [0] raw_pressed,
                                                                  // [32:1] now_ms, rest 0

    // event stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [7:0]                           o_m_axis_tdata,  // [4:0] event_count, rest 0
    output logic                                 o_m_axis_tuser,  // [0] event_kind

    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bchd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [bchd_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);
    import bchd_pkg::*;

    // config registers
    logic [CFG_DATA_WIDTH-1:0] r_debounce_time;
    logic [CFG_DATA_WIDTH-1:0] r_finish_timeout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time  <= DEBOUNCE_TIME_RESET;
            r_finish_timeout <= FINISH_TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TIME:  r_debounce_time  <= i_cfg_data;
                CFG_FINISH_TIMEOUT: r_finish_timeout <= i_cfg_data;
                default: ;  // unknown index, dropped
            endcase
        end
    end

    // input register
    logic                    r_in_valid;
    logic                    r_in_raw;
    logic [NOW_MS_WIDTH-1:0] r_in_now;
    logic                    proc_go;

    // evaluate when the output slot is free or drains this cycle
    assign proc_go         = r_in_valid && (!o_m_axis_tvalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_raw <= i_s_axis_tdata[0];
            r_in_now <= i_s_axis_tdata[NOW_MS_WIDTH:1];
        end
    end

    t_event core_event;

    bchd_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (proc_go),
        .i_raw_pressed    (r_in_raw),
        .i_now            (TIME_WIDTH'(r_in_now)),
        .i_debounce_time  (r_debounce_time),
        .i_finish_timeout (r_finish_timeout),
        .o_event          (core_event)
    );

    // output register
    logic                         r_out_valid;
    logic                         r_out_kind;
    logic [EVENT_COUNT_WIDTH-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_event.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_event.valid) begin
            r_out_kind  <= core_event.kind;
            r_out_count <= core_event.count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {{(8 - EVENT_COUNT_WIDTH){1'b0}}, r_out_count};

    // a new event only appears right after a poll was evaluated
    a_event_from_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc_go))
        else $error("event appeared without an evaluated poll");

    // a pending event is never overwritten by a fresh one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !core_event.valid)
        else $error("event overwrote an untaken result");

    // registers come out of reset at their defaults
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_debounce_time == DEBOUNCE_TIME_RESET &&
                      r_finish_timeout == FINISH_TIMEOUT_RESET))
        else $error("config registers not at reset values");

endmodule
